>>> design/fan_profile_drive_interpolator_macros.svh
// Assertion macros for the checker file of the fan profile drive interpolator.
`ifndef FAN_PROFILE_DRIVE_INTERPOLATOR_MACROS_SVH
`define FAN_PROFILE_DRIVE_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPDI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fpdi_pkg.sv
// Shared types, constants and a helper function of the fan profile drive interpolator.
package fpdi_pkg;

  localparam int SPEED_STEPS = 10;
  localparam int NUM_SLOTS   = SPEED_STEPS + 1;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int FULL_PM     = 1000;
  localparam int STEP_PM     = FULL_PM / SPEED_STEPS;
  // A fraction of 500 permille of a step equals half a step of remainder.
  localparam int HALF_STEP   = STEP_PM / 2;
  localparam int SPEED_W     = $clog2(FULL_PM + 1);
  localparam int REM_W       = $clog2(STEP_PM);

  // Interpolation lanes: phase delay, burst on, burst window.
  localparam int LANES    = 3;
  localparam int LANE_W   = 16;
  localparam int DIFF_W   = LANE_W + 1;
  localparam int PROD_W   = DIFF_W + REM_W;
  localparam int MAG_W    = PROD_W - 1;
  // (x * RECIP) >> RECIP_SH is at most one below floor(x / STEP_PM) for x < 2**MAG_W.
  localparam int RECIP_SH = 24;
  localparam int RECIP    = (1 << RECIP_SH) / STEP_PM;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int QUO_W    = MAG_W - $clog2(STEP_PM) + 1;
  localparam int VAL_W    = LANE_W + 2;

  localparam int LANE_PHASE = 0;
  localparam int LANE_ON    = 1;
  localparam int LANE_WIN   = 2;

  localparam logic [1:0] CFG_PROFILE_VALID = 2'd0;
  localparam logic [1:0] CFG_HAS_ENCODER   = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FULL = 2'd1,
    MODE_RUN  = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic [15:0] phase;
    logic [7:0]  on;
    logic [7:0]  win;
  } slot_t;

  // Per-item control and status carried down the pipeline.
  typedef struct packed {
    logic        drive_valid;
    drive_mode_t mode;
    logic        spinning;
    logic        stall;
    logic        hw_fault;
    logic        pending;
    logic        fan_fault;
  } rec_t;

  // Lower slot of a speed: the number of inner step boundaries at or below it.
  function automatic logic [SLOT_W-1:0] speed_lo(input logic [SPEED_W-1:0] s);
    logic [SLOT_W-1:0] lo;
    lo = '0;
    for (int k = 1; k < SPEED_STEPS; k++) begin
      lo = lo + SLOT_W'(s >= SPEED_W'(k * STEP_PM));
    end
    return lo;
  endfunction

endpackage

>>> design/fpdi_table.sv
// Profile slot memory: one write port, two registered read ports.
module fpdi_table
  import fpdi_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_t             wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr_a,
  input  logic [SLOT_W-1:0] rd_addr_b,
  output slot_t             rd_data_a,
  output slot_t             rd_data_b
);

  slot_t mem [NUM_SLOTS];
  slot_t rd_a_r;
  slot_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> design/fan_profile_drive_interpolator.sv
// Fan profile drive interpolator: top level with the control state and the drive pipeline.
//
// Usage. Items arrive as beats on the in_ stream: in_tuser carries the command (load slot,
// set speed, tick) and in_tdata the slot contents, speed request and sampled encoder and
// triac status. Every input beat yields exactly one out_ beat: out_tuser says whether a new
// triac drive command is issued, out_tdata holds the drive settings and the status flags.
// The cfg_ port writes profile_valid (index 0) and has_encoder (index 1); it is always
// ready and is meant to be written only while no beat is in flight.
// Load slot beats must fill all eleven slots before profile_valid is set.
// out_tvalid rises once an accepted beat has passed the stage 1, 2 and 3 registers and the
// output register. While the receiver keeps out_tready high, the pipeline takes one beat
// per cycle: the control flags update at the accepting edge, the profile memory is read at
// that edge through two ports (lower and upper slot), and three more stages form the
// interpolation: a 17x8 multiply, a reciprocal multiply for the divide by the step, and a
// quotient correction with the final add and the burst-on cap.
// Each stage holds while its successor is full, so in_tready stays high while any stage is
// empty, and a stalled receiver fills the pipeline before in_tready falls.
// Reset (rst_n low at a clock edge) clears the flags, the requested speed, both configuration
// registers and all stage valid bits; the profile memory keeps its contents and must be
// loaded again before use.
module fan_profile_drive_interpolator
  import fpdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: command.
  input  logic [1:0]  in_tuser,
  // Fields from bit 0: slot_index(4), slot_phase_delay(16), slot_burst_on(8),
  // slot_burst_window(8), speed_request(16), encoder_spinning, encoder_fault,
  // triac_config_error, one zero pad bit.
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: drive_valid.
  output logic        out_tuser,
  // Fields from bit 0: drive_mode(2), drive_phase_delay(16), drive_burst_on(8),
  // drive_burst_window(8), status_spinning, status_stall, status_hw_fault,
  // status_pending, fan_fault, one zero pad bit.
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);

  // Input fields.
  logic [SLOT_W-1:0] slot_index;
  slot_t             slot_wr;
  logic [15:0]       speed_request;
  logic              enc_spinning;
  logic              enc_fault;
  logic              triac_err;

  assign slot_index    = in_tdata[3:0];
  assign slot_wr.phase = in_tdata[19:4];
  assign slot_wr.on    = in_tdata[27:20];
  assign slot_wr.win   = in_tdata[35:28];
  assign speed_request = in_tdata[51:36];
  assign enc_spinning  = in_tdata[52];
  assign enc_fault     = in_tdata[53];
  assign triac_err     = in_tdata[54];

  // Configuration registers.
  logic profile_valid_r;
  logic has_encoder_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_valid_r <= 1'b0;
      has_encoder_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROFILE_VALID: profile_valid_r <= cfg_data;
        CFG_HAS_ENCODER:   has_encoder_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake chain: a stage loads when it is empty or its successor loads.
  logic v1_r, v2_r, v3_r, vo_r;
  logic ready1, ready2, ready3, ready_o;
  logic accept;

  assign ready_o   = !vo_r || out_tready;
  assign ready3    = !v3_r || ready_o;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;
  assign accept    = in_tvalid && in_tready;

  // Control state, updated at the accepting edge of each item.
  logic [SPEED_W-1:0] req_r, req_nxt;
  logic pending_r, pending_nxt;
  logic hw_r, hw_nxt;
  logic spin_r, spin_nxt;
  logic stall_r, stall_nxt;
  logic sys_r, sys_nxt;
  logic drive;
  logic wr_en;

  always_comb begin
    req_nxt     = req_r;
    pending_nxt = pending_r;
    hw_nxt      = hw_r;
    spin_nxt    = spin_r;
    stall_nxt   = stall_r;
    sys_nxt     = sys_r;
    drive       = 1'b0;
    wr_en       = 1'b0;
    unique case (in_tuser)
      CMD_LOAD: begin
        wr_en = (32'(slot_index) < NUM_SLOTS);
      end
      CMD_SPEED: begin
        if (profile_valid_r) begin
          req_nxt     = (speed_request > 16'(FULL_PM)) ? SPEED_W'(FULL_PM)
                                                       : speed_request[SPEED_W-1:0];
          pending_nxt = 1'b1;
        end
      end
      CMD_TICK: begin
        if (profile_valid_r) begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            drive       = 1'b1;
            // A triac configuration error counts only on a tick that drives.
            if (triac_err) begin
              hw_nxt = 1'b1;
            end
          end
          // The encoder, when present, has the last word on the hardware fault.
          if (has_encoder_r) begin
            hw_nxt    = enc_fault;
            spin_nxt  = enc_spinning;
            stall_nxt = !enc_spinning && (req_r != '0);
          end
          sys_nxt = stall_nxt || hw_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r     <= '0;
      pending_r <= 1'b0;
      hw_r      <= 1'b0;
      spin_r    <= 1'b0;
      stall_r   <= 1'b0;
      sys_r     <= 1'b0;
    end else if (accept) begin
      req_r     <= req_nxt;
      pending_r <= pending_nxt;
      hw_r      <= hw_nxt;
      spin_r    <= spin_nxt;
      stall_r   <= stall_nxt;
      sys_r     <= sys_nxt;
    end
  end

  // Split the requested speed into the lower slot and the remainder within the step.
  drive_mode_t        mode0;
  logic [SLOT_W-1:0]  lo0;
  logic [SPEED_W-1:0] rem_full0;
  logic [REM_W-1:0]   rem0;
  logic               run0;
  rec_t               rec0;

  always_comb begin
    if (req_r == '0) begin
      mode0 = MODE_OFF;
    end else if (req_r >= SPEED_W'(FULL_PM)) begin
      mode0 = MODE_FULL;
    end else begin
      mode0 = MODE_RUN;
    end
    lo0       = speed_lo(req_r);
    rem_full0 = req_r - SPEED_W'(32'(lo0) * STEP_PM);
    rem0      = rem_full0[REM_W-1:0];
    run0      = drive && (mode0 == MODE_RUN);

    rec0.drive_valid = drive;
    rec0.mode        = drive ? mode0 : MODE_OFF;
    rec0.spinning    = spin_nxt;
    rec0.stall       = stall_nxt;
    rec0.hw_fault    = hw_nxt;
    rec0.pending     = pending_nxt;
    rec0.fan_fault   = sys_nxt;
  end

  // Profile memory: loads write at acceptance, run-mode drive ticks read both neighbor slots.
  slot_t slot_lo, slot_hi;

  fpdi_table u_table (
    .clk       (clk),
    .wr_en     (accept && wr_en),
    .wr_addr   (slot_index),
    .wr_data   (slot_wr),
    .rd_en     (accept),
    .rd_addr_a (run0 ? lo0 : '0),
    .rd_addr_b (run0 ? SLOT_W'(lo0 + 1'b1) : '0),
    .rd_data_a (slot_lo),
    .rd_data_b (slot_hi)
  );

  // Stage 1: memory data arrives; choose exact, snapped or interpolated, and multiply.
  rec_t             rec1_r;
  logic [REM_W-1:0] rem1_r;
  logic             run1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec1_r <= rec0;
      rem1_r <= rem0;
      run1_r <= run0;
    end
  end

  logic [LANE_W-1:0]        lane_lo [LANES];
  logic [LANE_W-1:0]        lane_hi [LANES];
  logic [LANE_W-1:0]        base1   [LANES];
  logic signed [PROD_W-1:0] prod1   [LANES];
  logic signed [DIFF_W-1:0] diff1   [LANES];
  logic                     interp1;
  logic                     snap1;
  logic                     pick_hi1;

  always_comb begin
    lane_lo[LANE_PHASE] = slot_lo.phase;
    lane_lo[LANE_ON]    = LANE_W'(slot_lo.on);
    lane_lo[LANE_WIN]   = LANE_W'(slot_lo.win);
    lane_hi[LANE_PHASE] = slot_hi.phase;
    lane_hi[LANE_ON]    = LANE_W'(slot_hi.on);
    lane_hi[LANE_WIN]   = LANE_W'(slot_hi.win);
    // Snap when burst-on is zero at one neighbor and nonzero at the other.
    snap1    = ((slot_lo.on == '0) != (slot_hi.on == '0));
    pick_hi1 = snap1 && (rem1_r >= REM_W'(HALF_STEP));
    interp1  = run1_r && (rem1_r != '0) && !snap1;
    for (int i = 0; i < LANES; i++) begin
      diff1[i] = $signed({1'b0, lane_hi[i]}) - $signed({1'b0, lane_lo[i]});
      if (!run1_r) begin
        base1[i] = '0;
      end else if (pick_hi1) begin
        base1[i] = lane_hi[i];
      end else begin
        base1[i] = lane_lo[i];
      end
      // Both operands are sign-extended to the full product width first.
      prod1[i] = interp1 ? (PROD_W'(diff1[i]) * PROD_W'($signed({1'b0, rem1_r}))) : '0;
    end
  end

  // Stage 2: magnitude of the product times the reciprocal of the step.
  rec_t                     rec2_r;
  logic                     run2_r;
  logic                     interp2_r;
  logic [LANE_W-1:0]        base2_r [LANES];
  logic signed [PROD_W-1:0] prod2_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      rec2_r    <= rec1_r;
      run2_r    <= run1_r;
      interp2_r <= interp1;
      base2_r   <= base1;
      prod2_r   <= prod1;
    end
  end

  logic                     neg2  [LANES];
  logic [MAG_W-1:0]         mag2  [LANES];
  logic [MAG_W+RECIP_W-1:0] full2 [LANES];
  logic [QUO_W-1:0]         qest2 [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg2[i]  = prod2_r[i][PROD_W-1];
      mag2[i]  = neg2[i] ? MAG_W'(-prod2_r[i]) : MAG_W'(prod2_r[i]);
      full2[i] = (MAG_W+RECIP_W)'(mag2[i]) * (MAG_W+RECIP_W)'(RECIP);
      qest2[i] = full2[i][RECIP_SH +: QUO_W];
    end
  end

  // Stage 3: correct the quotient estimate, apply the sign, cap burst-on at the window.
  rec_t              rec3_r;
  logic              run3_r;
  logic              interp3_r;
  logic [LANE_W-1:0] base3_r [LANES];
  logic              neg3_r  [LANES];
  logic [MAG_W-1:0]  mag3_r  [LANES];
  logic [QUO_W-1:0]  qest3_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ready3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2_r) begin
      rec3_r    <= rec2_r;
      run3_r    <= run2_r;
      interp3_r <= interp2_r;
      base3_r   <= base2_r;
      neg3_r    <= neg2;
      mag3_r    <= mag2;
      qest3_r   <= qest2;
    end
  end

  logic [MAG_W-1:0]  rest3 [LANES];
  logic [QUO_W-1:0]  quo3  [LANES];
  logic [VAL_W-1:0]  val3  [LANES];
  logic [15:0]       phase3;
  logic [7:0]        on3;
  logic [7:0]        win3;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rest3[i] = mag3_r[i] - MAG_W'(MAG_W'(qest3_r[i]) * MAG_W'(STEP_PM));
      quo3[i]  = qest3_r[i] + QUO_W'(rest3[i] >= MAG_W'(STEP_PM));
      // Truncation toward zero: subtract the magnitude quotient for a falling segment.
      val3[i]  = neg3_r[i] ? (VAL_W'(base3_r[i]) - VAL_W'(quo3[i]))
                           : (VAL_W'(base3_r[i]) + VAL_W'(quo3[i]));
    end
    phase3 = val3[LANE_PHASE][15:0];
    on3    = val3[LANE_ON][7:0];
    win3   = val3[LANE_WIN][7:0];
    if (interp3_r && (on3 > win3)) begin
      on3 = win3;
    end
    if (!run3_r) begin
      phase3 = '0;
      on3    = '0;
      win3   = '0;
    end
  end

  // Output register.
  rec_t        reco_r;
  logic [15:0] phaseo_r;
  logic [7:0]  ono_r;
  logic [7:0]  wino_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ready_o) begin
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v3_r) begin
      reco_r   <= rec3_r;
      phaseo_r <= phase3;
      ono_r    <= on3;
      wino_r   <= win3;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tuser  = reco_r.drive_valid;
  assign out_tdata  = {1'b0, reco_r.fan_fault, reco_r.pending, reco_r.hw_fault,
                       reco_r.stall, reco_r.spinning, wino_r, ono_r, phaseo_r,
                       reco_r.mode};

endmodule

>>> design/fpdi_checker.sv
// Port-level checker of the fan profile drive interpolator and its bind statement.
`include "fan_profile_drive_interpolator_macros.svh"

module fpdi_checker
  import fpdi_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic [39:0] out_tdata
);

  // A held result must not change until it is taken.
  `FPDI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output beat changed while stalled")

  // Without a drive command all drive fields read zero.
  `FPDI_ASSERT_SAME(a_no_drive_zero, out_tvalid && !out_tuser, out_tdata[33:0] == '0, "drive fields nonzero without a drive")

  // Off and full-on drives carry no run parameters.
  `FPDI_ASSERT_SAME(a_mode_params, out_tvalid && out_tuser && (out_tdata[1:0] != MODE_RUN), out_tdata[33:2] == '0, "run parameters on an off or full-on drive")

  // The fan fault is exactly stall or hardware fault.
  `FPDI_ASSERT_SAME(a_fault_sum, out_tvalid, out_tdata[38] == (out_tdata[35] || out_tdata[36]), "fan fault disagrees with stall and hardware fault")

  // A drive consumes the pending request.
  `FPDI_ASSERT_SAME(a_drive_clears, out_tvalid && out_tuser, !out_tdata[37], "request still pending after a drive")

endmodule

bind fan_profile_drive_interpolator fpdi_checker u_fpdi_checker (.*);
